### hdl/lfps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared types, register indexes and constants of the line-follow steering
// block.
// ----------------------------------------------------------------------------
package lfps_pkg;

    localparam int SUM_WIDTH_DEF   = 24;
    localparam int CURVE_LIMIT_DEF = 23;

    localparam int POS_W   = 12;
    localparam int GAIN_W  = 16;
    localparam int DRIVE_W = 13;
    localparam int SENS_W  = 6;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 16;
    localparam int CNT_W   = 5;
    localparam int FRAC_W  = 16;

    localparam logic [DRIVE_W-1:0] BASE_DRIVE_RST  = 13'd3000;
    localparam logic [DRIVE_W-1:0] MAX_DRIVE_RST   = 13'd7200;
    localparam logic [DRIVE_W-1:0] PIVOT_DRIVE_RST = 13'd4000;

    localparam logic signed [POS_W-1:0] DIR_THRESHOLD = 12'sd512;
    localparam logic [CNT_W-1:0]        CURVE_SHARP   = 5'd20;

    typedef enum logic [IDX_W-1:0] {
        CFG_SETPOINT    = 3'd0,
        CFG_GAIN_P      = 3'd1,
        CFG_GAIN_I      = 3'd2,
        CFG_GAIN_D      = 3'd3,
        CFG_BASE_DRIVE  = 3'd4,
        CFG_MAX_DRIVE   = 3'd5,
        CFG_PIVOT_DRIVE = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_PID   = 2'd0,
        KIND_PIV_R = 2'd1,
        KIND_PIV_L = 2'd2,
        KIND_STOP  = 2'd3
    } result_kind_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'b00,
        DIR_POS  = 2'b01,
        DIR_NEG  = 2'b11
    } turn_dir_t;

    typedef enum logic [2:0] {
        PIV_NONE  = 3'b001,
        PIV_RIGHT = 3'b010,
        PIV_LEFT  = 3'b100
    } pivot_state_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  setpoint;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [DRIVE_W-1:0]       base_drive;
        logic [DRIVE_W-1:0]       max_drive;
        logic [DRIVE_W-1:0]       pivot_drive;
    } cfg_regs_t;

    typedef struct packed {
        logic         valid;
        result_kind_t kind;
    } pipe_ctl_t;

endpackage

### hdl/lfps_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_sample_if
// Input channel: one control tick with line position and sensor data.
// ----------------------------------------------------------------------------
interface lfps_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [lfps_pkg::POS_W-1:0]   line_position;
    logic [lfps_pkg::SENS_W-1:0]         sensor_bits;
    logic                                curve_marker;
    logic                                turn_check;

    modport source (
        output valid, line_position, sensor_bits, curve_marker, turn_check,
        input  ready
    );
    modport sink (
        input  valid, line_position, sensor_bits, curve_marker, turn_check,
        output ready
    );
endinterface

### hdl/lfps_drive_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_drive_if
// Output channel: wheel drive values and the pivot flag of one item.
// ----------------------------------------------------------------------------
interface lfps_drive_if;
    logic                          valid;
    logic                          ready;
    logic [lfps_pkg::DRIVE_W-1:0]  left_drive;
    logic [lfps_pkg::DRIVE_W-1:0]  right_drive;
    logic                          pivoting;

    modport source (
        output valid, left_drive, right_drive, pivoting,
        input  ready
    );
    modport sink (
        input  valid, left_drive, right_drive, pivoting,
        output ready
    );
endinterface

### hdl/lfps_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lfps_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lfps_pkg::IDX_W-1:0]    index;
    logic [lfps_pkg::DATA_W-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### hdl/lfps_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_cfg_regs
// Configuration register file; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module lfps_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    lfps_cfg_if.sink            cfg,
    output lfps_pkg::cfg_regs_t regs
);

    lfps_pkg::cfg_regs_t regs_reg;
    lfps_pkg::cfg_regs_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                lfps_pkg::CFG_SETPOINT:
                    regs_next.setpoint = signed'(cfg.data[lfps_pkg::POS_W-1:0]);
                lfps_pkg::CFG_GAIN_P:
                    regs_next.gain_p = signed'(cfg.data);
                lfps_pkg::CFG_GAIN_I:
                    regs_next.gain_i = signed'(cfg.data);
                lfps_pkg::CFG_GAIN_D:
                    regs_next.gain_d = signed'(cfg.data);
                lfps_pkg::CFG_BASE_DRIVE:
                    regs_next.base_drive = cfg.data[lfps_pkg::DRIVE_W-1:0];
                lfps_pkg::CFG_MAX_DRIVE:
                    regs_next.max_drive = cfg.data[lfps_pkg::DRIVE_W-1:0];
                lfps_pkg::CFG_PIVOT_DRIVE:
                    regs_next.pivot_drive = cfg.data[lfps_pkg::DRIVE_W-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.setpoint    <= '0;
            regs_reg.gain_p      <= '0;
            regs_reg.gain_i      <= '0;
            regs_reg.gain_d      <= '0;
            regs_reg.base_drive  <= lfps_pkg::BASE_DRIVE_RST;
            regs_reg.max_drive   <= lfps_pkg::MAX_DRIVE_RST;
            regs_reg.pivot_drive <= lfps_pkg::PIVOT_DRIVE_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

### hdl/lfps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_front
// Input register and state update: error, saturating sum, derivative term,
// curve counter, turn direction and pivot mode.
// ----------------------------------------------------------------------------
module lfps_front #(
    parameter int SUM_WIDTH   = lfps_pkg::SUM_WIDTH_DEF,
    parameter int CURVE_LIMIT = lfps_pkg::CURVE_LIMIT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    lfps_sample_if.sink                 sample,
    input  lfps_pkg::cfg_regs_t         regs,
    input  logic                        take_en,
    input  logic                        pass_en,
    output logic                        hold_valid,
    output lfps_pkg::pipe_ctl_t         ctl,
    output logic signed [12:0]          err,
    output logic signed [SUM_WIDTH-1:0] sum,
    output logic signed [13:0]          diff
);

    logic                              v0_reg;
    logic signed [lfps_pkg::POS_W-1:0] pos_reg;
    logic [lfps_pkg::SENS_W-1:0]       sens_reg;
    logic                              mark_reg;
    logic                              turn_reg;

    logic signed [12:0]          prev_err_reg;
    logic signed [12:0]          prev_err_next;
    logic signed [SUM_WIDTH-1:0] err_sum_reg;
    logic signed [SUM_WIDTH-1:0] err_sum_next;
    logic [lfps_pkg::CNT_W-1:0]  curve_cnt_reg;
    logic [lfps_pkg::CNT_W-1:0]  curve_cnt_next;
    lfps_pkg::turn_dir_t         dir_reg;
    lfps_pkg::turn_dir_t         dir_next;
    lfps_pkg::pivot_state_t      piv_reg;
    lfps_pkg::pivot_state_t      piv_next;

    lfps_pkg::pipe_ctl_t         ctl_reg;
    lfps_pkg::result_kind_t      kind_next;
    logic signed [12:0]          err_reg;
    logic signed [SUM_WIDTH-1:0] sum_reg;
    logic signed [13:0]          diff_reg;

    logic                        fire;
    logic signed [12:0]          err_c;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic signed [SUM_WIDTH-1:0] sum_sat;
    logic signed [13:0]          diff_c;
    logic [lfps_pkg::CNT_W-1:0]  cnt_clr;
    logic                        sharp_ok;

    assign sample.ready = take_en;
    assign hold_valid   = v0_reg;
    assign fire         = v0_reg && pass_en;
    assign ctl          = ctl_reg;
    assign err          = err_reg;
    assign sum          = sum_reg;
    assign diff         = diff_reg;

    assign err_c    = 13'(regs.setpoint) - 13'(pos_reg);
    assign sum_wide = (SUM_WIDTH + 1)'(err_sum_reg) + (SUM_WIDTH + 1)'(err_c);
    assign diff_c   = 14'(err_c) - 14'(prev_err_reg);

    always_comb
    begin
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1])
        begin
            sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH - 1){1'b0}}}
                                          : {1'b0, {(SUM_WIDTH - 1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SUM_WIDTH-1:0];
        end
    end

    always_comb
    begin
        cnt_clr  = mark_reg ? '0 : curve_cnt_reg;
        sharp_ok = 1'b0;

        prev_err_next  = prev_err_reg;
        err_sum_next   = err_sum_reg;
        curve_cnt_next = curve_cnt_reg;
        dir_next       = dir_reg;
        piv_next       = piv_reg;
        kind_next      = lfps_pkg::KIND_PID;

        if (piv_reg != lfps_pkg::PIV_NONE)
        begin
            if (sens_reg != '0)
            begin
                piv_next  = lfps_pkg::PIV_NONE;
                kind_next = lfps_pkg::KIND_STOP;
            end
            else if (piv_reg == lfps_pkg::PIV_RIGHT)
            begin
                kind_next = lfps_pkg::KIND_PIV_R;
            end
            else
            begin
                kind_next = lfps_pkg::KIND_PIV_L;
            end
        end
        else
        begin
            prev_err_next = err_c;
            err_sum_next  = sum_sat;

            if (cnt_clr < lfps_pkg::CNT_W'(CURVE_LIMIT))
            begin
                curve_cnt_next = lfps_pkg::CNT_W'(cnt_clr + 1'b1);
            end
            else
            begin
                curve_cnt_next = cnt_clr;
            end

            if (pos_reg > lfps_pkg::DIR_THRESHOLD)
            begin
                dir_next = lfps_pkg::DIR_POS;
            end
            else if (pos_reg < -lfps_pkg::DIR_THRESHOLD)
            begin
                dir_next = lfps_pkg::DIR_NEG;
            end

            sharp_ok = curve_cnt_next < lfps_pkg::CURVE_SHARP;

            if (turn_reg)
            begin
                if (dir_next == lfps_pkg::DIR_NEG
                    || (sharp_ok && dir_next == lfps_pkg::DIR_POS))
                begin
                    piv_next  = lfps_pkg::PIV_RIGHT;
                    kind_next = lfps_pkg::KIND_PIV_R;
                end
                else if (dir_next == lfps_pkg::DIR_POS)
                begin
                    piv_next  = lfps_pkg::PIV_LEFT;
                    kind_next = lfps_pkg::KIND_PIV_L;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            ctl_reg       <= '{valid: 1'b0, kind: lfps_pkg::KIND_PID};
            prev_err_reg  <= '0;
            err_sum_reg   <= '0;
            curve_cnt_reg <= '0;
            dir_reg       <= lfps_pkg::DIR_NONE;
            piv_reg       <= lfps_pkg::PIV_NONE;
        end
        else
        begin
            if (take_en)
            begin
                v0_reg <= sample.valid;
            end
            if (pass_en)
            begin
                ctl_reg <= '{valid: v0_reg, kind: kind_next};
            end
            if (fire)
            begin
                prev_err_reg  <= prev_err_next;
                err_sum_reg   <= err_sum_next;
                curve_cnt_reg <= curve_cnt_next;
                dir_reg       <= dir_next;
                piv_reg       <= piv_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_en && sample.valid)
        begin
            pos_reg  <= sample.line_position;
            sens_reg <= sample.sensor_bits;
            mark_reg <= sample.curve_marker;
            turn_reg <= sample.turn_check;
        end
        if (fire)
        begin
            err_reg  <= err_c;
            sum_reg  <= sum_sat;
            diff_reg <= diff_c;
        end
    end

    // A pivot can only start from an item that carries a turn check.
    assert property (@(posedge clk) disable iff (!rst_n)
        (piv_reg == lfps_pkg::PIV_NONE && piv_next != lfps_pkg::PIV_NONE && fire)
        |-> turn_reg)
        else $error("pivot started without a turn check");

    // The integral sum is frozen for every item handled during a pivot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (piv_reg != lfps_pkg::PIV_NONE) |=> $stable(err_sum_reg))
        else $error("error sum changed during a pivot");

    // The counter never runs past its limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (curve_cnt_reg <= lfps_pkg::CNT_W'(CURVE_LIMIT)
                  || curve_cnt_reg == $past(curve_cnt_reg)))
        else $error("curve counter beyond its limit");

endmodule

### hdl/lfps_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_mult
// Product stage: the three gain products of the PID terms, registered.
// ----------------------------------------------------------------------------
module lfps_mult #(
    parameter int SUM_WIDTH = lfps_pkg::SUM_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lfps_pkg::cfg_regs_t                   regs,
    input  logic                                  pass_en,
    input  lfps_pkg::pipe_ctl_t                   ctl_in,
    input  logic signed [12:0]                    err,
    input  logic signed [SUM_WIDTH-1:0]           sum,
    input  logic signed [13:0]                    diff,
    output lfps_pkg::pipe_ctl_t                   ctl_out,
    output logic signed [28:0]                    p_term,
    output logic signed [SUM_WIDTH+15:0]          i_term,
    output logic signed [29:0]                    d_term
);

    lfps_pkg::pipe_ctl_t          ctl_reg;
    logic signed [28:0]           p_reg;
    logic signed [SUM_WIDTH+15:0] i_reg;
    logic signed [29:0]           d_reg;
    logic signed [28:0]           p_next;
    logic signed [SUM_WIDTH+15:0] i_next;
    logic signed [29:0]           d_next;

    assign p_next = 29'(regs.gain_p) * 29'(err);
    assign i_next = (SUM_WIDTH + 16)'(regs.gain_i) * (SUM_WIDTH + 16)'(sum);
    assign d_next = 30'(regs.gain_d) * 30'(diff);

    assign ctl_out = ctl_reg;
    assign p_term  = p_reg;
    assign i_term  = i_reg;
    assign d_term  = d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '{valid: 1'b0, kind: lfps_pkg::KIND_PID};
        end
        else if (pass_en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pass_en && ctl_in.valid)
        begin
            p_reg <= p_next;
            i_reg <= i_next;
            d_reg <= d_next;
        end
    end

endmodule

### hdl/lfps_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_mix
// Output stage: sums the terms, mixes them with the base drive, clamps each
// wheel and selects pivot or stop values into the result register.
// ----------------------------------------------------------------------------
module lfps_mix #(
    parameter int SUM_WIDTH = lfps_pkg::SUM_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lfps_pkg::cfg_regs_t          regs,
    input  logic                         pass_en,
    input  lfps_pkg::pipe_ctl_t          ctl_in,
    input  logic signed [28:0]           p_term,
    input  logic signed [SUM_WIDTH+15:0] i_term,
    input  logic signed [29:0]           d_term,
    lfps_drive_if.source                 drive
);

    localparam int TW = SUM_WIDTH + 18;
    localparam int QW = TW + 1;
    localparam int DW = lfps_pkg::DRIVE_W;
    localparam int FW = lfps_pkg::FRAC_W;

    logic                 valid_reg;
    logic [DW-1:0]        left_reg;
    logic [DW-1:0]        right_reg;
    logic                 piv_reg;
    logic [DW-1:0]        left_next;
    logic [DW-1:0]        right_next;
    logic                 piv_next;

    logic signed [TW-1:0] total;
    logic signed [QW-1:0] base_q;
    logic signed [QW-1:0] max_q;
    logic signed [QW-1:0] q_left;
    logic signed [QW-1:0] q_right;
    logic [DW-1:0]        w_left;
    logic [DW-1:0]        w_right;

    assign total   = TW'(p_term) + TW'(i_term) + TW'(d_term);
    assign base_q  = QW'(signed'({1'b0, regs.base_drive, {FW{1'b0}}}));
    assign max_q   = QW'(signed'({1'b0, regs.max_drive, {FW{1'b0}}}));
    assign q_left  = base_q + QW'(total);
    assign q_right = base_q - QW'(total);

    always_comb
    begin
        if (q_left < 0)
        begin
            w_left = '0;
        end
        else if (q_left > max_q)
        begin
            w_left = regs.max_drive;
        end
        else
        begin
            w_left = q_left[FW+DW-1:FW];
        end

        if (q_right < 0)
        begin
            w_right = '0;
        end
        else if (q_right > max_q)
        begin
            w_right = regs.max_drive;
        end
        else
        begin
            w_right = q_right[FW+DW-1:FW];
        end
    end

    always_comb
    begin
        case (ctl_in.kind)
            lfps_pkg::KIND_PID:
            begin
                left_next  = w_left;
                right_next = w_right;
                piv_next   = 1'b0;
            end
            lfps_pkg::KIND_PIV_R:
            begin
                left_next  = '0;
                right_next = regs.pivot_drive;
                piv_next   = 1'b1;
            end
            lfps_pkg::KIND_PIV_L:
            begin
                left_next  = regs.pivot_drive;
                right_next = '0;
                piv_next   = 1'b1;
            end
            default:
            begin
                left_next  = '0;
                right_next = '0;
                piv_next   = 1'b0;
            end
        endcase
    end

    assign drive.valid       = valid_reg;
    assign drive.left_drive  = left_reg;
    assign drive.right_drive = right_reg;
    assign drive.pivoting    = piv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pass_en)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pass_en && ctl_in.valid)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            piv_reg   <= piv_next;
        end
    end

endmodule

### hdl/line_follow_pid_steering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_pid_steering
// Positional PID steering with differential wheel drive and pivot turns.
// ----------------------------------------------------------------------------
// The block accepts one control tick per clock cycle unless a held output
// has filled every stage, and returns exactly one result per tick, in order.
// It has four register stages: the input register, the state update stage
// that computes the error, the saturating sum and the derivative term, the
// stage holding the three gain products, and the result register after the
// mix and clamp logic. Backpressure on the output stalls the stages in turn,
// so up to four items can be in flight. Configuration writes are always
// accepted and should be made while no item is in flight.
// ----------------------------------------------------------------------------
module line_follow_pid_steering #(
    parameter int SUM_WIDTH   = lfps_pkg::SUM_WIDTH_DEF,
    parameter int CURVE_LIMIT = lfps_pkg::CURVE_LIMIT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    lfps_sample_if.sink  sample,
    lfps_drive_if.source drive,
    lfps_cfg_if.sink     cfg
);

    lfps_pkg::cfg_regs_t          regs;
    lfps_pkg::pipe_ctl_t          ctl_s1;
    lfps_pkg::pipe_ctl_t          ctl_s2;
    logic                         v0;
    logic                         en0;
    logic                         en1;
    logic                         en2;
    logic                         en3;
    logic signed [12:0]           err;
    logic signed [SUM_WIDTH-1:0]  sum;
    logic signed [13:0]           diff;
    logic signed [28:0]           p_term;
    logic signed [SUM_WIDTH+15:0] i_term;
    logic signed [29:0]           d_term;

    assign en3 = !drive.valid || drive.ready;
    assign en2 = !ctl_s2.valid || en3;
    assign en1 = !ctl_s1.valid || en2;
    assign en0 = !v0 || en1;

    lfps_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    lfps_front #(
        .SUM_WIDTH   (SUM_WIDTH),
        .CURVE_LIMIT (CURVE_LIMIT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .regs       (regs),
        .take_en    (en0),
        .pass_en    (en1),
        .hold_valid (v0),
        .ctl        (ctl_s1),
        .err        (err),
        .sum        (sum),
        .diff       (diff)
    );

    lfps_mult #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .regs    (regs),
        .pass_en (en2),
        .ctl_in  (ctl_s1),
        .err     (err),
        .sum     (sum),
        .diff    (diff),
        .ctl_out (ctl_s2),
        .p_term  (p_term),
        .i_term  (i_term),
        .d_term  (d_term)
    );

    lfps_mix #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_mix (
        .clk     (clk),
        .rst_n   (rst_n),
        .regs    (regs),
        .pass_en (en3),
        .ctl_in  (ctl_s2),
        .p_term  (p_term),
        .i_term  (i_term),
        .d_term  (d_term),
        .drive   (drive)
    );

    // The input only stalls when every stage is full and the output is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (drive.valid && !drive.ready && ctl_s1.valid
                           && ctl_s2.valid && v0))
        else $error("input stalled with room in the pipeline");

    // During a pivot at least one wheel is stopped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (drive.valid && drive.pivoting)
        |-> (drive.left_drive == '0 || drive.right_drive == '0))
        else $error("pivot result drives both wheels");

endmodule
